// ===== hdl/sss_pkg.sv =====
// sss_pkg: shared types and codes for the scoped symbol stack
// item structs, request/kind/status codes, controller-datapath command and status structs
// no dependencies
`default_nettype none

package sss_pkg;

  // fixed field widths of the result item
  localparam int IDX_W   = 10;
  localparam int REG_W   = 11;
  localparam int DEPTH_W = 11;

  // register number offset from entry index
  localparam logic [31:0] REG_OFFSET = 32'd2;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_END    = 2'd2;

  // insert kind codes
  localparam logic [1:0] KIN_UNDEF  = 2'd0;
  localparam logic [1:0] KIN_GLOBAL = 2'd1;
  localparam logic [1:0] KIN_LOCAL  = 2'd2;
  localparam logic [1:0] KIN_PROC   = 2'd3;

  // stored scope codes
  localparam logic [1:0] SCOPE_GLOBAL = 2'd0;
  localparam logic [1:0] SCOPE_LOCAL  = 2'd1;
  localparam logic [1:0] SCOPE_PROC   = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // result selection codes from controller to datapath
  localparam logic [2:0] RES_INSERT = 3'd0;
  localparam logic [2:0] RES_FULL   = 3'd1;
  localparam logic [2:0] RES_FOUND  = 3'd2;
  localparam logic [2:0] RES_MISS   = 3'd3;
  localparam logic [2:0] RES_PLAIN  = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] name_key;
    logic [1:0]  kind_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IDX_W-1:0]   entry_index;
    logic [REG_W-1:0]   reg_number;
    logic [1:0]         kind_out;
    logic [DEPTH_W-1:0] depth_now;
  } out_item_t;

  // controller commands to the datapath
  typedef struct packed {
    logic       load_item;
    logic       do_insert;
    logic       rd_top;
    logic       rd_next;
    logic       pop_one;
    logic       clr_proc;
    logic       res_load;
    logic [2:0] res_sel;
  } sss_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic [1:0] req;
    logic       full;
    logic       empty;
    logic       match;
    logic       last_zero;
    logic       top_local;
  } sss_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sss_ram.sv =====
// sss_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module sss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sss_ctrl.sv =====
// sss_ctrl: request sequencer for the scoped symbol stack
// depends on sss_pkg (command/status structs, request and result codes)
`default_nettype none

module sss_ctrl
  import sss_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire sss_stat_t stat,
  output sss_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SRCH   = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.req)
          REQ_INSERT: begin
            cmd.res_load = 1'b1;
            if (stat.full) begin
              cmd.res_sel = RES_FULL;
            end else begin
              cmd.do_insert = 1'b1;
              cmd.res_sel   = RES_INSERT;
            end
            state_nxt = S_OUT;
          end
          REQ_LOOKUP: begin
            if (stat.empty) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_MISS;
              state_nxt    = S_OUT;
            end else begin
              cmd.rd_top = 1'b1;
              state_nxt  = S_SRCH;
            end
          end
          REQ_END: begin
            if (stat.empty) begin
              cmd.clr_proc = 1'b1;
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_PLAIN;
              state_nxt    = S_OUT;
            end else begin
              cmd.rd_top = 1'b1;
              state_nxt  = S_POP;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_PLAIN;
            state_nxt    = S_OUT;
          end
        endcase
      end
      // walk down from the top, one entry per cycle
      S_SRCH: begin
        if (stat.match) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_FOUND;
          state_nxt    = S_OUT;
        end else if (stat.last_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_MISS;
          state_nxt    = S_OUT;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      // pop local entries off the top
      S_POP: begin
        if (stat.top_local) begin
          cmd.pop_one = 1'b1;
          if (stat.last_zero) begin
            cmd.clr_proc = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_PLAIN;
            state_nxt    = S_OUT;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end else begin
          cmd.clr_proc = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_PLAIN;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sss_dp.sv =====
// sss_dp: datapath of the scoped symbol stack: item registers, depth and scope
// state, key and kind RAMs, compare logic and result register
// depends on sss_pkg and sss_ram
`default_nettype none

module sss_dp
  import sss_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_item,
  input  wire sss_cmd_t  cmd,
  output sss_stat_t      stat,
  output out_item_t      res
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // latched request
  logic [1:0]           req_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [1:0]           kin_r;

  // stack state
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          proc_r;
  logic          proc_nxt;
  logic [AW-1:0] last_r;
  logic [AW-1:0] last_nxt;

  // ram ports
  logic                 ram_re;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic [KEY_WIDTH-1:0] key_rd;
  logic [1:0]           kind_rd;
  logic [1:0]           ins_kind;
  logic [AW-1:0]        top_idx;
  logic [AW-1:0]        last_dec;

  // result
  out_item_t     res_r;
  out_item_t     res_nxt;
  logic [AW-1:0] idx_sel;
  logic [31:0]   idx_ext;
  logic [31:0]   reg_ext;
  logic [31:0]   depth_ext;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      req_r <= in_item.req_type;
      key_r <= in_item.name_key[KEY_WIDTH-1:0];
      kin_r <= in_item.kind_in;
    end
  end

  // scope of a new entry
  always_comb begin
    if (kin_r == KIN_UNDEF) begin
      ins_kind = proc_r ? SCOPE_LOCAL : SCOPE_GLOBAL;
    end else begin
      ins_kind = kin_r - 2'd1;
    end
  end

  assign waddr    = count_r[AW-1:0];
  assign top_idx  = AW'(count_r - CW'(1));
  assign last_dec = last_r - AW'(1);

  // read address: top of stack at start, then one below the last entry read
  always_comb begin
    ram_re = cmd.rd_top | cmd.rd_next;
    if (cmd.rd_top) begin
      raddr = top_idx;
    end else if (last_r == '0) begin
      raddr = '0;
    end else begin
      raddr = last_dec;
    end
  end

  always_comb begin
    last_nxt = last_r;
    if (cmd.rd_top) begin
      last_nxt = top_idx;
    end else if (cmd.rd_next) begin
      last_nxt = last_dec;
    end
  end

  // depth and local mode
  always_comb begin
    count_nxt = count_r;
    if (cmd.do_insert) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop_one) begin
      count_nxt = CW'(last_r);
    end
    proc_nxt = proc_r;
    if (cmd.do_insert && kin_r == KIN_PROC) begin
      proc_nxt = 1'b1;
    end else if (cmd.clr_proc) begin
      proc_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      proc_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      proc_r  <= proc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
  end

  sss_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.do_insert),
    .waddr (waddr),
    .wdata (key_r),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (key_rd)
  );

  sss_ram #(
    .WIDTH (2),
    .DEPTH (TABLE_DEPTH)
  ) u_kind_ram (
    .clk   (clk),
    .we    (cmd.do_insert),
    .waddr (waddr),
    .wdata (ins_kind),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (kind_rd)
  );

  // status back to the controller
  assign stat.req       = req_r;
  assign stat.full      = (count_r == CW'(TABLE_DEPTH));
  assign stat.empty     = (count_r == '0);
  assign stat.match     = (key_rd == key_r);
  assign stat.last_zero = (last_r == '0);
  assign stat.top_local = (kind_rd == SCOPE_LOCAL);

  // result formatting, depth taken after this cycle's update
  assign idx_sel   = (cmd.res_sel == RES_FOUND) ? last_r : waddr;
  assign idx_ext   = 32'(idx_sel);
  assign reg_ext   = idx_ext + REG_OFFSET;
  assign depth_ext = 32'(count_nxt);

  always_comb begin
    res_nxt           = '0;
    res_nxt.depth_now = depth_ext[DEPTH_W-1:0];
    unique case (cmd.res_sel)
      RES_INSERT: begin
        res_nxt.status      = STAT_OK;
        res_nxt.entry_index = idx_ext[IDX_W-1:0];
        res_nxt.reg_number  = reg_ext[REG_W-1:0];
        res_nxt.kind_out    = ins_kind;
      end
      RES_FOUND: begin
        res_nxt.status      = STAT_OK;
        res_nxt.entry_index = idx_ext[IDX_W-1:0];
        res_nxt.reg_number  = reg_ext[REG_W-1:0];
        res_nxt.kind_out    = kind_rd;
      end
      RES_FULL: begin
        res_nxt.status = STAT_FULL;
      end
      RES_MISS: begin
        res_nxt.status = STAT_MISS;
      end
      default: begin
        res_nxt.status = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== hdl/scoped_symbol_stack.sv =====
// scoped_symbol_stack: top level of the scoped symbol stack
// depends on sss_pkg, sss_ctrl, sss_dp (and sss_ram below it)
`default_nettype none

// A stack of symbol entries (name key plus scope) for a compiler front end.
// One item is handled at a time. With the result taken at once, an insert,
// the unused request code and a lookup or end-scope request on an empty
// table pass through the accept, decode and result steps. A lookup adds a
// search step for each entry compared from the top down, and an end-scope
// request a pop step for each entry read while popping local entries, so a
// lookup miss over a full table walks all TABLE_DEPTH entries. The key and
// kind RAMs have a single read port, walked one entry per cycle.
// The result is held until taken, then the block is ready again the next
// cycle. No clearing pass is needed after reset.

module scoped_symbol_stack
  import sss_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  sss_cmd_t  cmd;
  sss_stat_t stat;

  // request sequencer
  sss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and compare datapath
  sss_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cmd     (cmd),
    .stat    (stat),
    .res     (out_item)
  );

endmodule

`default_nettype wire

// ===== tb/tb_scoped_symbol_stack.sv =====
// tb_scoped_symbol_stack: self-checking bench for the scoped symbol stack
// drives insert/lookup/end-scope items through a queue-fed driver, predicts each result
// depends on sss_pkg and scoped_symbol_stack
`default_nettype none

module tb_scoped_symbol_stack;
  import sss_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 64;
  localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_WIDTH);
  localparam int POOL_SIZE   = 24;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_CHUNKS = 4;
  localparam int CHUNK_ITEMS = 50;

  // request code with no operation
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // testbench-side copy of the symbol stack
  logic [63:0] sym_key [TABLE_DEPTH];
  logic [1:0]  sym_scope [TABLE_DEPTH];
  int unsigned sym_count = 0;
  bit          proc_open = 1'b0;

  in_item_t    pending_reqs[$];
  out_item_t   expected_results[$];
  logic [63:0] name_pool [POOL_SIZE];
  int          queued_items = 0;
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  scoped_symbol_stack #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted result of one request, updates the stack copy
  function automatic out_item_t symbol_request(in_item_t req);
    out_item_t   res;
    logic [1:0]  scope;
    logic [63:0] key;
    bit          found;
    res   = '0;
    scope = SCOPE_GLOBAL;
    key   = req.name_key & KEY_MASK;
    found = 1'b0;
    unique case (req.req_type)
      REQ_INSERT: begin
        if (sym_count >= TABLE_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          unique case (req.kind_in)
            KIN_UNDEF:  scope = proc_open ? SCOPE_LOCAL : SCOPE_GLOBAL;
            KIN_GLOBAL: scope = SCOPE_GLOBAL;
            KIN_LOCAL:  scope = SCOPE_LOCAL;
            default:    scope = SCOPE_PROC;
          endcase
          sym_key[sym_count]   = key;
          sym_scope[sym_count] = scope;
          if (req.kind_in == KIN_PROC) proc_open = 1'b1;
          res.status      = STAT_OK;
          res.entry_index = IDX_W'(sym_count);
          res.reg_number  = REG_W'(sym_count + REG_OFFSET);
          res.kind_out    = scope;
          sym_count++;
        end
      end
      REQ_LOOKUP: begin
        // top-down search, nearest entry wins
        for (int i = int'(sym_count) - 1; i >= 0 && !found; i--) begin
          if (sym_key[i] == key) begin
            found           = 1'b1;
            res.status      = STAT_OK;
            res.entry_index = IDX_W'(i);
            res.reg_number  = REG_W'(i + REG_OFFSET);
            res.kind_out    = sym_scope[i];
          end
        end
        if (!found) res.status = STAT_MISS;
      end
      REQ_END: begin
        // pop locals off the top, close local mode
        while (sym_count > 0 && sym_scope[sym_count - 1] == SCOPE_LOCAL) sym_count--;
        proc_open  = 1'b0;
        res.status = STAT_OK;
      end
      default: res.status = STAT_OK;
    endcase
    res.depth_now = DEPTH_W'(sym_count);
    return res;
  endfunction

  // driver: present queued items, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(symbol_request(in_item));
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, compare each result with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: status %0d index %0d reg %0d kind %0d depth %0d",
                     out_item.status, out_item.entry_index, out_item.reg_number,
                     out_item.kind_out, out_item.depth_now);
        end else begin
          want = expected_results.pop_front();
          if (out_item.status !== want.status || out_item.entry_index !== want.entry_index ||
              out_item.reg_number !== want.reg_number || out_item.kind_out !== want.kind_out ||
              out_item.depth_now !== want.depth_now) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display(
                "mismatch exp/got: st %0d/%0d idx %0d/%0d reg %0d/%0d kind %0d/%0d dep %0d/%0d",
                want.status, out_item.status, want.entry_index, out_item.entry_index,
                want.reg_number, out_item.reg_number, want.kind_out, out_item.kind_out,
                want.depth_now, out_item.depth_now);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // mostly known names, some one-bit near misses, some fresh names
  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 60) return name_pool[$urandom_range(POOL_SIZE - 1)];
    if (r < 80) return name_pool[$urandom_range(POOL_SIZE - 1)] ^ (64'd1 << $urandom_range(63));
    return rand_key();
  endfunction

  function automatic void push_req(logic [1:0] req, logic [63:0] key, logic [1:0] kind);
    in_item_t it;
    it.req_type = req;
    it.name_key = key;
    it.kind_in  = kind;
    pending_reqs.push_back(it);
    queued_items++;
  endfunction

  // procedure open, a short body of local and global inserts and lookups, then end scope
  function automatic void gen_procedure();
    int r;
    push_req(REQ_INSERT, pick_key(), KIN_PROC);
    repeat ($urandom_range(8, 1)) begin
      r = $urandom_range(99);
      if (r < 35) push_req(REQ_INSERT, pick_key(), KIN_UNDEF);
      else if (r < 45) push_req(REQ_INSERT, pick_key(), KIN_LOCAL);
      else if (r < 50) push_req(REQ_INSERT, pick_key(), KIN_GLOBAL);
      else push_req(REQ_LOOKUP, pick_key(), 2'($urandom_range(3)));
    end
    push_req(REQ_END, rand_key(), 2'($urandom_range(3)));
  endfunction

  task automatic set_idling(int mode);
    unique case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
      default: begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
  endtask

  // sender pauses until every predicted result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // run limit
  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [63:0] top_key;
    name_pool[0] = 64'd0;
    name_pool[1] = {64{1'b1}};
    for (int i = 2; i < POOL_SIZE; i++) name_pool[i] = rand_key();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, scope rules, duplicates, popping, unused code
    set_idling(3);
    push_req(REQ_LOOKUP, 64'd0, KIN_UNDEF);
    push_req(REQ_END, {64{1'b1}}, KIN_PROC);
    push_req(REQ_UNUSED, {64{1'b1}}, KIN_PROC);
    push_req(REQ_INSERT, 64'd0, KIN_GLOBAL);
    push_req(REQ_INSERT, {64{1'b1}}, KIN_UNDEF);
    push_req(REQ_INSERT, 64'h1234_5678_9abc_def0, KIN_PROC);
    push_req(REQ_INSERT, 64'h8000_0000_0000_0001, KIN_UNDEF);
    push_req(REQ_INSERT, 64'd0, KIN_LOCAL);
    push_req(REQ_LOOKUP, 64'd0, KIN_GLOBAL);
    push_req(REQ_LOOKUP, {64{1'b1}}, KIN_LOCAL);
    push_req(REQ_LOOKUP, 64'h8000_0000_0000_0001, KIN_PROC);
    push_req(REQ_INSERT, 64'h0000_0000_ffff_0000, KIN_GLOBAL);
    push_req(REQ_END, 64'd0, KIN_UNDEF);
    push_req(REQ_INSERT, 64'h7fff_ffff_ffff_fffe, KIN_UNDEF);
    push_req(REQ_LOOKUP, 64'd0, KIN_UNDEF);
    push_req(REQ_INSERT, 64'h0f0f_0f0f_0f0f_0f0f, KIN_PROC);
    push_req(REQ_INSERT, 64'hf0f0_f0f0_f0f0_f0f0, KIN_LOCAL);
    push_req(REQ_INSERT, 64'h0123_4567_89ab_cdef, KIN_UNDEF);
    push_req(REQ_END, 64'd0, KIN_GLOBAL);
    push_req(REQ_LOOKUP, 64'h0123_4567_89ab_cdef, KIN_UNDEF);
    push_req(REQ_LOOKUP, 64'h0f0f_0f0f_0f0f_0f0f, KIN_UNDEF);
    push_req(REQ_UNUSED, 64'd0, KIN_UNDEF);
    push_req(REQ_INSERT, 64'h5555_5555_5555_5555, KIN_LOCAL);
    push_req(REQ_END, 64'haaaa_aaaa_aaaa_aaaa, KIN_LOCAL);
    push_req(REQ_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, KIN_UNDEF);
    wait_drained();

    // fill to the last slot inside a procedure, then hit the full table
    set_idling(0);
    push_req(REQ_INSERT, pick_key(), KIN_PROC);
    top_key = 64'd0;
    repeat (TABLE_DEPTH - int'(sym_count) - 1) begin
      top_key = ($urandom_range(9) == 0) ? pick_key() : rand_key();
      push_req(REQ_INSERT, top_key, $urandom_range(1) ? KIN_UNDEF : KIN_LOCAL);
    end
    push_req(REQ_INSERT, rand_key(), KIN_UNDEF);
    push_req(REQ_INSERT, rand_key(), KIN_GLOBAL);
    push_req(REQ_INSERT, rand_key(), KIN_LOCAL);
    push_req(REQ_INSERT, rand_key(), KIN_PROC);
    push_req(REQ_LOOKUP, 64'hdead_beef_0000_0001, KIN_UNDEF);
    push_req(REQ_LOOKUP, 64'd0, KIN_UNDEF);
    push_req(REQ_LOOKUP, top_key, KIN_UNDEF);
    push_req(REQ_END, 64'd0, KIN_UNDEF);
    push_req(REQ_END, 64'd0, KIN_UNDEF);
    wait_drained();

    // random: mostly well-formed procedures, some noise, rotating idle patterns
    for (int c = 0; c < RAND_CHUNKS; c++) begin
      set_idling(c % 4);
      queued_items = 0;
      while (queued_items < CHUNK_ITEMS) begin
        if ($urandom_range(99) < 85)
          gen_procedure();
        else
          push_req(2'($urandom_range(3)), $urandom_range(1) ? pick_key() : rand_key(),
                   2'($urandom_range(3)));
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
